// ===== rtl/core/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and fixed widths shared by the face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    localparam int COORD_W  = 32;              // Q16.16 corner coordinate
    localparam int EDGE_W   = COORD_W + 1;     // edge difference, signed
    localparam int EMAG_W   = COORD_W;         // edge magnitude
    localparam int SMAG_W   = 30;              // scaled magnitudes stay below 2^30
    localparam int PROD_W   = 2 * SMAG_W;      // product of two scaled magnitudes
    localparam int CROSS_W  = PROD_W + 2;      // signed cross component
    localparam int CMAG_W   = PROD_W + 1;      // cross component magnitude
    localparam int LEN2_W   = PROD_W + 2;      // sum of three squares
    localparam int ROOT_W   = LEN2_W / 2;      // floor square root
    localparam int REM_W    = ROOT_W + 3;      // square root remainder
    localparam int NORM_TOP = SMAG_W - 1;      // leading one lands on this bit
    localparam int OUT_W    = 16;

    localparam int CROSS_STAGES = 6;
    localparam int NORM_STAGES  = 5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_TRI  = 2'd1;
    localparam logic [1:0] ST_DEGEN    = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    localparam logic [1:0] MODE_FILE  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;

    localparam logic [7:0] TRI_VERTS = 8'd3;

    localparam logic [OUT_W-1:0] OUT_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 16'h8000;
    localparam logic [31:0] SAT_POS_MAG = 32'd32767;
    localparam logic [31:0] SAT_NEG_MAG = 32'd32768;

    typedef struct packed {
        logic [7:0]                face_vertex_count;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_face_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic [1:0]              face_status;
    } t_face_out;

    // control that travels alongside every pipeline stage
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [2:0] neg;
    } t_ctl;

    typedef struct packed {
        t_ctl                         ctl;
        logic [2:0][CMAG_W-1:0]       mag;
    } t_cross_item;

    typedef struct packed {
        t_ctl                         ctl;
        logic [2:0][SMAG_W-1:0]       mag;
    } t_vec_item;

    typedef struct packed {
        t_vec_item                    vec;
        logic [LEN2_W-1:0]            len2;
    } t_len_item;

    typedef struct packed {
        t_vec_item                    vec;
        logic [ROOT_W-1:0]            root;
    } t_root_item;

endpackage

`default_nettype wire

// ===== rtl/core/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal
// Takes one face per cycle; busy never rises.
// Depth is set by the 31-stage square root and the (F+1)-stage divider.
// Synchronous active-low reset empties the pipeline and sets the mode to MODE_RESET.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire tfn_pkg::t_face_in  i_face,
    output logic                    o_result_valid,
    output tfn_pkg::t_face_out      o_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_data
);

    localparam int Q_W   = NORMAL_FRAC_BITS + 1;
    localparam int OUT_W = tfn_pkg::OUT_W;
    localparam int RESULT_DELAY = tfn_pkg::CROSS_STAGES + tfn_pkg::NORM_STAGES
                                + tfn_pkg::ROOT_W + Q_W + 2;

    logic                   mode_off;
    logic [1:0]             r_mode_q;
    logic                   accept;
    tfn_pkg::t_cross_item   cross_item;
    tfn_pkg::t_len_item     len_item;
    tfn_pkg::t_root_item    root_item;
    tfn_pkg::t_ctl          div_ctl;
    logic [2:0][Q_W-1:0]    div_quot;

    logic                   r_result_valid;
    tfn_pkg::t_face_out     r_result;
    tfn_pkg::t_face_out     n_result;
    logic [OUT_W-1:0]       v_lane [3];
    logic [31:0]            v_q32  [3];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_q <= tfn_pkg::MODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode_q <= i_cfg_data;
        end
    end

    // flag kept for the checks below: the block is switched off
    assign mode_off = (r_mode_q == tfn_pkg::MODE_FILE);

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_mode  (r_mode_q),
        .i_face  (i_face),
        .o_item  (cross_item)
    );

    tfn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (cross_item),
        .o_item  (len_item)
    );

    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (len_item),
        .o_item  (root_item)
    );

    tfn_div #(
        .FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (root_item),
        .o_ctl   (div_ctl),
        .o_quot  (div_quot)
    );

    // saturate to 16 bits, zero normal for anything but a good triangle
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_q32[i] = 32'(div_quot[i]);
            if (div_ctl.status != tfn_pkg::ST_OK) begin
                v_lane[i] = '0;
            end else if (div_ctl.neg[i]) begin
                v_lane[i] = (v_q32[i] > tfn_pkg::SAT_NEG_MAG) ? tfn_pkg::OUT_MIN
                                                               : OUT_W'(32'd0 - v_q32[i]);
            end else begin
                v_lane[i] = (v_q32[i] > tfn_pkg::SAT_POS_MAG) ? tfn_pkg::OUT_MAX
                                                               : OUT_W'(v_q32[i]);
            end
        end
        n_result.normal_x    = v_lane[0];
        n_result.normal_y    = v_lane[1];
        n_result.normal_z    = v_lane[2];
        n_result.face_status = div_ctl.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= div_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##RESULT_DELAY o_result_valid)
        else $error("request did not produce a result strobe");

    a_disabled_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && mode_off |-> ##RESULT_DELAY
            (o_result.face_status == tfn_pkg::ST_DISABLED))
        else $error("disabled mode did not report disabled status");

    a_fail_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.face_status != tfn_pkg::ST_OK |->
            o_result.normal_x == '0 && o_result.normal_y == '0
            && o_result.normal_z == '0)
        else $error("non-ok status with a non-zero normal");

    a_ok_nonzero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.face_status == tfn_pkg::ST_OK |->
            o_result.normal_x != '0 || o_result.normal_y != '0
            || o_result.normal_z != '0)
        else $error("ok status with a zero normal");

endmodule

`default_nettype wire

// ===== rtl/core/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, edge prescale and exact cross product; six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [1:0]             i_mode,
    input  wire tfn_pkg::t_face_in      i_face,
    output tfn_pkg::t_cross_item        o_item
);

    localparam int EDGE_W  = tfn_pkg::EDGE_W;
    localparam int EMAG_W  = tfn_pkg::EMAG_W;
    localparam int SMAG_W  = tfn_pkg::SMAG_W;
    localparam int PROD_W  = tfn_pkg::PROD_W;
    localparam int CROSS_W = tfn_pkg::CROSS_W;
    localparam int CMAG_W  = tfn_pkg::CMAG_W;
    localparam int COORD_W = tfn_pkg::COORD_W;

    // stage 1: edges b-a (0..2) and c-a (3..5)
    logic                r_s1_valid;
    logic [1:0]          r_s1_status;
    logic [EDGE_W-1:0]   r_s1_edge [6];
    logic [1:0]          n_s1_status;
    logic [EDGE_W-1:0]   n_s1_edge [6];

    // stage 2: magnitudes
    logic                r_s2_valid;
    logic [1:0]          r_s2_status;
    logic [5:0]          r_s2_neg;
    logic [EMAG_W-1:0]   r_s2_mag [6];
    logic [5:0]          n_s2_neg;
    logic [EMAG_W-1:0]   n_s2_mag [6];
    logic [EDGE_W-1:0]   v_abs [6];

    // stage 3: prescaled magnitudes
    logic                r_s3_valid;
    logic [1:0]          r_s3_status;
    logic [5:0]          r_s3_neg;
    logic [SMAG_W-1:0]   r_s3_mag [6];
    logic [SMAG_W-1:0]   n_s3_mag [6];
    logic                v_hi31;
    logic                v_hi30;
    logic [1:0]          v_sr;

    // stage 4: partial products
    logic                r_s4_valid;
    logic [1:0]          r_s4_status;
    logic [5:0]          r_s4_neg;
    logic [PROD_W-1:0]   r_s4_prod [6];
    logic [5:0]          n_s4_neg;
    logic [PROD_W-1:0]   n_s4_prod [6];

    // stage 5: signed cross product
    logic                r_s5_valid;
    logic [1:0]          r_s5_status;
    logic [CROSS_W-1:0]  r_s5_cross [3];
    logic [CROSS_W-1:0]  n_s5_cross [3];
    logic [CROSS_W-1:0]  v_sp [6];

    // stage 6: cross magnitudes
    tfn_pkg::t_ctl       r_s6_ctl;
    logic [2:0][CMAG_W-1:0] r_s6_mag;
    tfn_pkg::t_ctl       n_s6_ctl;
    logic [2:0][CMAG_W-1:0] n_s6_mag;
    logic [CROSS_W-1:0]  v_cabs [3];

    always_comb begin
        if (i_mode == tfn_pkg::MODE_FILE) begin
            n_s1_status = tfn_pkg::ST_DISABLED;
        end else if (i_face.face_vertex_count != tfn_pkg::TRI_VERTS) begin
            n_s1_status = tfn_pkg::ST_NOT_TRI;
        end else begin
            n_s1_status = tfn_pkg::ST_OK;
        end
        n_s1_edge[0] = {i_face.bx[COORD_W-1], i_face.bx}
                     - {i_face.ax[COORD_W-1], i_face.ax};
        n_s1_edge[1] = {i_face.by_coord[COORD_W-1], i_face.by_coord}
                     - {i_face.ay[COORD_W-1], i_face.ay};
        n_s1_edge[2] = {i_face.bz[COORD_W-1], i_face.bz}
                     - {i_face.az[COORD_W-1], i_face.az};
        n_s1_edge[3] = {i_face.cx[COORD_W-1], i_face.cx}
                     - {i_face.ax[COORD_W-1], i_face.ax};
        n_s1_edge[4] = {i_face.cy[COORD_W-1], i_face.cy}
                     - {i_face.ay[COORD_W-1], i_face.ay};
        n_s1_edge[5] = {i_face.cz[COORD_W-1], i_face.cz}
                     - {i_face.az[COORD_W-1], i_face.az};
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_s2_neg[i] = r_s1_edge[i][EDGE_W-1];
            v_abs[i]    = n_s2_neg[i] ? (~r_s1_edge[i] + EDGE_W'(1)) : r_s1_edge[i];
            n_s2_mag[i] = v_abs[i][EMAG_W-1:0];
        end
    end

    // the largest magnitude sits below 2^32, so at most two bits come off
    always_comb begin
        v_hi31 = 1'b0;
        v_hi30 = 1'b0;
        for (int i = 0; i < 6; i++) begin
            v_hi31 = v_hi31 | r_s2_mag[i][EMAG_W-1];
            v_hi30 = v_hi30 | r_s2_mag[i][EMAG_W-2];
        end
        v_sr = v_hi31 ? 2'd2 : (v_hi30 ? 2'd1 : 2'd0);
        for (int i = 0; i < 6; i++) begin
            n_s3_mag[i] = SMAG_W'(r_s2_mag[i] >> v_sr);
        end
    end

    always_comb begin
        n_s4_prod[0] = PROD_W'(r_s3_mag[1]) * PROD_W'(r_s3_mag[5]);
        n_s4_prod[1] = PROD_W'(r_s3_mag[2]) * PROD_W'(r_s3_mag[4]);
        n_s4_prod[2] = PROD_W'(r_s3_mag[2]) * PROD_W'(r_s3_mag[3]);
        n_s4_prod[3] = PROD_W'(r_s3_mag[0]) * PROD_W'(r_s3_mag[5]);
        n_s4_prod[4] = PROD_W'(r_s3_mag[0]) * PROD_W'(r_s3_mag[4]);
        n_s4_prod[5] = PROD_W'(r_s3_mag[1]) * PROD_W'(r_s3_mag[3]);
        n_s4_neg[0]  = r_s3_neg[1] ^ r_s3_neg[5];
        n_s4_neg[1]  = r_s3_neg[2] ^ r_s3_neg[4];
        n_s4_neg[2]  = r_s3_neg[2] ^ r_s3_neg[3];
        n_s4_neg[3]  = r_s3_neg[0] ^ r_s3_neg[5];
        n_s4_neg[4]  = r_s3_neg[0] ^ r_s3_neg[4];
        n_s4_neg[5]  = r_s3_neg[1] ^ r_s3_neg[3];
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            v_sp[k] = r_s4_neg[k] ? (~{2'b00, r_s4_prod[k]} + CROSS_W'(1))
                                  : {2'b00, r_s4_prod[k]};
        end
        n_s5_cross[0] = v_sp[0] - v_sp[1];
        n_s5_cross[1] = v_sp[2] - v_sp[3];
        n_s5_cross[2] = v_sp[4] - v_sp[5];
    end

    always_comb begin
        n_s6_ctl.valid  = r_s5_valid;
        n_s6_ctl.status = r_s5_status;
        for (int i = 0; i < 3; i++) begin
            n_s6_ctl.neg[i] = r_s5_cross[i][CROSS_W-1];
            v_cabs[i]       = n_s6_ctl.neg[i] ? (~r_s5_cross[i] + CROSS_W'(1))
                                              : r_s5_cross[i];
            n_s6_mag[i]     = v_cabs[i][CMAG_W-1:0];
        end
        // zero area, also when the prescale wiped out the cross product
        if (r_s5_status == tfn_pkg::ST_OK && r_s5_cross[0] == '0
                && r_s5_cross[1] == '0 && r_s5_cross[2] == '0) begin
            n_s6_ctl.status = tfn_pkg::ST_DEGEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_ctl   <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_ctl   <= n_s6_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_status <= n_s1_status;
        r_s1_edge   <= n_s1_edge;
        r_s2_status <= r_s1_status;
        r_s2_neg    <= n_s2_neg;
        r_s2_mag    <= n_s2_mag;
        r_s3_status <= r_s2_status;
        r_s3_neg    <= r_s2_neg;
        r_s3_mag    <= n_s3_mag;
        r_s4_status <= r_s3_status;
        r_s4_neg    <= n_s4_neg;
        r_s4_prod   <= n_s4_prod;
        r_s5_status <= r_s4_status;
        r_s5_cross  <= n_s5_cross;
        r_s6_mag    <= n_s6_mag;
    end

    always_comb begin
        o_item.ctl = r_s6_ctl;
        o_item.mag = r_s6_mag;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tfn_norm.sv =====
// ----------------------------------------------------------------------------
// tfn_norm
// Leading-one search, cross rescale to [2^29, 2^30), squared length; five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_norm (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tfn_pkg::t_cross_item   i_item,
    output tfn_pkg::t_len_item          o_item
);

    localparam int CMAG_W  = tfn_pkg::CMAG_W;
    localparam int SMAG_W  = tfn_pkg::SMAG_W;
    localparam int PROD_W  = tfn_pkg::PROD_W;
    localparam int LEN2_W  = tfn_pkg::LEN2_W;
    localparam int CHUNK_W = 16;
    localparam int CHUNKS  = 4;
    localparam int OR_W    = CHUNK_W * CHUNKS;
    localparam int POS_W   = 6;
    localparam int SHIFT_W = 5;

    // stage 7: per-chunk leading one
    tfn_pkg::t_ctl          r_s7_ctl;
    logic [2:0][CMAG_W-1:0] r_s7_mag;
    logic [CHUNKS-1:0]      r_s7_nz;
    logic [CHUNKS-1:0][3:0] r_s7_pos;
    logic [CHUNKS-1:0]      n_s7_nz;
    logic [CHUNKS-1:0][3:0] n_s7_pos;
    logic [OR_W-1:0]        v_or;

    // stage 8: shift direction and amount
    tfn_pkg::t_ctl          r_s8_ctl;
    logic [2:0][CMAG_W-1:0] r_s8_mag;
    logic                   r_s8_right;
    logic [SHIFT_W-1:0]     r_s8_amt;
    logic                   n_s8_right;
    logic [SHIFT_W-1:0]     n_s8_amt;
    logic [POS_W-1:0]       v_lead;

    // stage 9: scaled magnitudes
    tfn_pkg::t_ctl          r_s9_ctl;
    logic [2:0][SMAG_W-1:0] r_s9_mag;
    logic [2:0][SMAG_W-1:0] n_s9_mag;
    logic [CMAG_W-1:0]      v_sh [3];

    // stage 10: squares
    tfn_pkg::t_ctl          r_s10_ctl;
    logic [2:0][SMAG_W-1:0] r_s10_mag;
    logic [PROD_W-1:0]      r_s10_sq [3];
    logic [PROD_W-1:0]      n_s10_sq [3];

    // stage 11: length squared
    tfn_pkg::t_ctl          r_s11_ctl;
    logic [2:0][SMAG_W-1:0] r_s11_mag;
    logic [LEN2_W-1:0]      r_s11_len2;
    logic [LEN2_W-1:0]      n_s11_len2;

    // the OR of the magnitudes has its leading one where the largest does
    always_comb begin
        v_or = OR_W'(i_item.mag[0] | i_item.mag[1] | i_item.mag[2]);
        for (int j = 0; j < CHUNKS; j++) begin
            n_s7_nz[j]  = |v_or[CHUNK_W*j +: CHUNK_W];
            n_s7_pos[j] = 4'd0;
            for (int b = 0; b < CHUNK_W; b++) begin
                if (v_or[CHUNK_W*j + b]) begin
                    n_s7_pos[j] = 4'(b);
                end
            end
        end
    end

    always_comb begin
        v_lead = '0;
        for (int j = 0; j < CHUNKS; j++) begin
            if (r_s7_nz[j]) begin
                v_lead = {2'(j), r_s7_pos[j]};
            end
        end
        n_s8_right = v_lead >= POS_W'(tfn_pkg::NORM_TOP);
        if (n_s8_right) begin
            n_s8_amt = SHIFT_W'(v_lead - POS_W'(tfn_pkg::NORM_TOP));
        end else begin
            n_s8_amt = SHIFT_W'(POS_W'(tfn_pkg::NORM_TOP) - v_lead);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_sh[i]     = r_s8_right ? (r_s8_mag[i] >> r_s8_amt)
                                     : (r_s8_mag[i] << r_s8_amt);
            n_s9_mag[i] = v_sh[i][SMAG_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s10_sq[i] = PROD_W'(r_s9_mag[i]) * PROD_W'(r_s9_mag[i]);
        end
        n_s11_len2 = LEN2_W'(r_s10_sq[0]) + LEN2_W'(r_s10_sq[1]) + LEN2_W'(r_s10_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_ctl  <= '0;
            r_s8_ctl  <= '0;
            r_s9_ctl  <= '0;
            r_s10_ctl <= '0;
            r_s11_ctl <= '0;
        end else begin
            r_s7_ctl  <= i_item.ctl;
            r_s8_ctl  <= r_s7_ctl;
            r_s9_ctl  <= r_s8_ctl;
            r_s10_ctl <= r_s9_ctl;
            r_s11_ctl <= r_s10_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_mag   <= i_item.mag;
        r_s7_nz    <= n_s7_nz;
        r_s7_pos   <= n_s7_pos;
        r_s8_mag   <= r_s7_mag;
        r_s8_right <= n_s8_right;
        r_s8_amt   <= n_s8_amt;
        r_s9_mag   <= n_s9_mag;
        r_s10_mag  <= r_s9_mag;
        r_s10_sq   <= n_s10_sq;
        r_s11_mag  <= r_s10_mag;
        r_s11_len2 <= n_s11_len2;
    end

    always_comb begin
        o_item.vec.ctl = r_s11_ctl;
        o_item.vec.mag = r_s11_mag;
        o_item.len2    = r_s11_len2;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tfn_pkg::t_len_item     i_item,
    output tfn_pkg::t_root_item         o_item
);

    localparam int SMAG_W = tfn_pkg::SMAG_W;
    localparam int LEN2_W = tfn_pkg::LEN2_W;
    localparam int ROOT_W = tfn_pkg::ROOT_W;
    localparam int REM_W  = tfn_pkg::REM_W;

    tfn_pkg::t_ctl          r_ctl  [ROOT_W];
    logic [2:0][SMAG_W-1:0] r_mag  [ROOT_W];
    logic [LEN2_W-1:0]      r_x    [ROOT_W];
    logic [REM_W-1:0]       r_rem  [ROOT_W];
    logic [ROOT_W-1:0]      r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        tfn_pkg::t_ctl          ctl_in;
        logic [2:0][SMAG_W-1:0] mag_in;
        logic [LEN2_W-1:0]      x_in;
        logic [REM_W-1:0]       rem_in;
        logic [ROOT_W-1:0]      root_in;
        logic [REM_W-1:0]       rem_sh;
        logic [REM_W-1:0]       trial;
        logic                   take;
        logic [REM_W-1:0]       n_rem;

        if (k == 0) begin : g_first
            always_comb begin
                ctl_in  = i_item.vec.ctl;
                mag_in  = i_item.vec.mag;
                x_in    = i_item.len2;
                rem_in  = '0;
                root_in = '0;
            end
        end else begin : g_next
            always_comb begin
                ctl_in  = r_ctl[k-1];
                mag_in  = r_mag[k-1];
                x_in    = r_x[k-1];
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
            end
        end

        // remainder never exceeds twice the root, so its top two bits are free
        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], x_in[LEN2_W-1 -: 2]};
            trial  = REM_W'({root_in, 2'b01});
            take   = rem_sh >= trial;
            n_rem  = take ? (rem_sh - trial) : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_mag[k]  <= mag_in;
            r_x[k]    <= {x_in[LEN2_W-3:0], 2'b00};
            r_rem[k]  <= n_rem;
            r_root[k] <= {root_in[ROOT_W-2:0], take};
        end
    end

    always_comb begin
        o_item.vec.ctl = r_ctl[ROOT_W-1];
        o_item.vec.mag = r_mag[ROOT_W-1];
        o_item.root    = r_root[ROOT_W-1];
    end

endmodule

`default_nettype wire

// ===== rtl/core/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div
// Rounded quotient |v| * 2^F / r for three lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tfn_pkg::t_root_item    i_item,
    output tfn_pkg::t_ctl               o_ctl,
    output logic [2:0][FRAC_BITS:0]     o_quot
);

    localparam int SMAG_W = tfn_pkg::SMAG_W;
    localparam int ROOT_W = tfn_pkg::ROOT_W;
    localparam int Q_W    = FRAC_BITS + 1;          // quotient never exceeds 2^F
    localparam int NUM_W  = SMAG_W + FRAC_BITS + 1;
    localparam int DREM_W = ROOT_W + 1;

    // numerator set-up stage
    tfn_pkg::t_ctl          r_p_ctl;
    logic [2:0][NUM_W-1:0]  r_p_num;
    logic [ROOT_W-1:0]      r_p_root;
    logic [2:0][NUM_W-1:0]  n_p_num;

    tfn_pkg::t_ctl          r_ctl  [Q_W];
    logic [ROOT_W-1:0]      r_root [Q_W];
    logic [2:0][DREM_W-1:0] r_rem  [Q_W];
    logic [2:0][Q_W-1:0]    r_lo   [Q_W];
    logic [2:0][Q_W-1:0]    r_q    [Q_W];

    // round to nearest: add half the divisor before dividing
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p_num[i] = (NUM_W'(i_item.vec.mag[i]) << FRAC_BITS)
                       + NUM_W'(i_item.root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else begin
            r_p_ctl <= i_item.vec.ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_num  <= n_p_num;
        r_p_root <= i_item.root;
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        tfn_pkg::t_ctl          ctl_in;
        logic [ROOT_W-1:0]      root_in;
        logic [2:0][DREM_W-1:0] rem_in;
        logic [2:0][Q_W-1:0]    lo_in;
        logic [2:0][Q_W-1:0]    q_in;
        logic [2:0][DREM_W-1:0] rem_sh;
        logic [2:0][DREM_W-1:0] n_rem;
        logic [2:0][Q_W-1:0]    n_q;

        if (j == 0) begin : g_first
            always_comb begin
                ctl_in  = r_p_ctl;
                root_in = r_p_root;
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = DREM_W'(r_p_num[i][NUM_W-1 -: SMAG_W]);
                    lo_in[i]  = r_p_num[i][Q_W-1:0];
                end
                q_in = '0;
            end
        end else begin : g_next
            always_comb begin
                ctl_in  = r_ctl[j-1];
                root_in = r_root[j-1];
                rem_in  = r_rem[j-1];
                lo_in   = r_lo[j-1];
                q_in    = r_q[j-1];
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem_sh[i] = {rem_in[i][DREM_W-2:0], lo_in[i][Q_W-1]};
                if (rem_sh[i] >= DREM_W'(root_in)) begin
                    n_rem[i] = rem_sh[i] - DREM_W'(root_in);
                    n_q[i]   = {q_in[i][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[i] = rem_sh[i];
                    n_q[i]   = {q_in[i][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j] <= '0;
            end else begin
                r_ctl[j] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[j] <= root_in;
            r_rem[j]  <= n_rem;
            for (int i = 0; i < 3; i++) begin
                r_lo[j][i] <= {lo_in[i][Q_W-2:0], 1'b0};
            end
            r_q[j]    <= n_q;
        end
    end

    assign o_ctl  = r_ctl[Q_W-1];
    assign o_quot = r_q[Q_W-1];

endmodule

`default_nettype wire
